### rtl/skt_pkg.sv
// ---------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Request and response transaction layouts, field widths, command codes and
// configuration register defaults.
// ---------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_W   = 16;
  localparam int CENTS_W = 24;

  // APB data and address widths
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Default table depth
  localparam int TABLE_DEPTH_DEF = 16;

  // Reset value of the spend limit, in cents
  localparam logic [CENTS_W-1:0] SPEND_LIMIT_RST = CENTS_W'(10000);

  // Register indexes
  localparam logic REG_SPEND_LIMIT = 1'b0;

  // Command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [KEY_W-1:0]   key;
    logic [CENTS_W-1:0] balance;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [CENTS_W-1:0] found_balance;
    logic               over_limit;
    logic               rejected;
  } rsp_t;

endpackage

### rtl/skt_ram.sv
// ---------------------------------------------------------------------------
// skt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sorted_key_table_lookup.sv
// ---------------------------------------------------------------------------
// sorted_key_table_lookup: ordered key and balance table with search
// Keeps key and balance pairs in ascending key order in a RAM, inserts new
// pairs after equal keys and looks up the oldest entry matching a key.
// ---------------------------------------------------------------------------
//
//  port group   role      handshake               payload
//  req          input     req_valid / req_ready   req_data (skt_pkg::req_t)
//  rsp          output    rsp_valid / rsp_ready   rsp_data (skt_pkg::rsp_t)
//  apb          config    psel/penable/pready     paddr, pwdata, prdata
//
//  A search reads one entry a cycle through the single RAM read port and
//  ends on the oldest matching entry, on the first greater key or after
//  the last entry. A load scans for its slot, moves each later entry up
//  by one and writes the pair; a full-table load is rejected without a
//  scan. One transaction is in work at a time. The result register frees
//  the request side while a result is stalled.
//  Reset empties the table at once (entry count cleared, no RAM sweep).
//
module sorted_key_table_lookup #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  skt_pkg::req_t                 req_data,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output skt_pkg::rsp_t                 rsp_data,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skt_pkg::APB_AW-1:0]    paddr,
  input  logic [skt_pkg::APB_DW-1:0]    pwdata,
  output logic [skt_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  import skt_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int EW  = KEY_W + CENTS_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  // Control registers
  logic [2:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic               chk_valid, chk_valid_next;
  logic [CW-1:0]      chk_idx, chk_idx_next;
  logic [CW-1:0]      sidx, sidx_next;
  logic               pend, pend_next;
  logic               rsp_valid_next;
  logic [CENTS_W-1:0] spend_limit;

  // Payload registers
  logic               cmd_r, cmd_r_next;
  logic [KEY_W-1:0]   key_r, key_r_next;
  logic [CENTS_W-1:0] bal_r, bal_r_next;
  logic [CW-1:0]      pos, pos_next;
  logic [AW-1:0]      wa, wa_next;
  logic               res_found, res_found_next;
  logic [CENTS_W-1:0] res_bal, res_bal_next;
  logic               res_rej, res_rej_next;
  rsp_t               rsp_data_next;

  // RAM port signals
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [CENTS_W-1:0] rd_bal;
  logic [CW-1:0]      sidx_dec;
  logic               cfg_wr;

  skt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[CENTS_W +: KEY_W];
  assign rd_bal   = ram_rdata[CENTS_W-1:0];
  assign sidx_dec = sidx - CW'(1);

  assign req_ready = (state == ST_IDLE);

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SPEND_LIMIT);
  assign prdata = (paddr[2] == REG_SPEND_LIMIT) ?
                  {{(APB_DW-CENTS_W){1'b0}}, spend_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spend_limit <= SPEND_LIMIT_RST;
    end else if (cfg_wr) begin
      spend_limit <= pwdata[CENTS_W-1:0];
    end
  end

  // Sequencer: scan, move entries up, insert, deliver
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    chk_valid_next = chk_valid;
    chk_idx_next   = chk_idx;
    sidx_next      = sidx;
    pend_next      = pend;
    cmd_r_next     = cmd_r;
    key_r_next     = key_r;
    bal_r_next     = bal_r;
    pos_next       = pos;
    wa_next        = wa;
    res_found_next = res_found;
    res_bal_next   = res_bal;
    res_rej_next   = res_rej;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_data_next  = rsp_data;
    ram_we         = 1'b0;
    ram_waddr      = wa;
    ram_wdata      = ram_rdata;
    ram_raddr      = '0;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd_r_next     = req_data.cmd;
          key_r_next     = req_data.key;
          bal_r_next     = req_data.balance;
          res_found_next = 1'b0;
          res_bal_next   = '0;
          res_rej_next   = 1'b0;
          idx_next       = '0;
          chk_valid_next = 1'b0;
          if (req_data.cmd == CMD_LOAD && count == FULL) begin
            res_rej_next = 1'b1;
            state_next   = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (chk_valid && cmd_r == CMD_SEARCH && rd_key == key_r) begin
          // hit on the oldest equal entry
          res_found_next = 1'b1;
          res_bal_next   = rd_bal;
          state_next     = ST_DONE;
        end else if (chk_valid && rd_key > key_r) begin
          // stored keys have passed the query
          if (cmd_r == CMD_SEARCH) begin
            state_next = ST_DONE;
          end else begin
            pos_next   = chk_idx;
            sidx_next  = count;
            pend_next  = 1'b0;
            state_next = ST_SHIFT;
          end
        end else if (idx != count) begin
          // issue the next entry read
          ram_raddr      = idx[AW-1:0];
          chk_idx_next   = idx;
          chk_valid_next = 1'b1;
          idx_next       = idx + CW'(1);
        end else begin
          chk_valid_next = 1'b0;
          if (!chk_valid) begin
            if (cmd_r == CMD_SEARCH) begin
              state_next = ST_DONE;
            end else begin
              pos_next   = count;
              sidx_next  = count;
              pend_next  = 1'b0;
              state_next = ST_SHIFT;
            end
          end
        end
      end

      ST_SHIFT: begin
        // write back the entry read last cycle one slot higher
        ram_we    = pend;
        ram_waddr = wa;
        ram_wdata = ram_rdata;
        if (sidx != pos) begin
          ram_raddr = sidx_dec[AW-1:0];
          wa_next   = sidx[AW-1:0];
          sidx_next = sidx_dec;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = ST_INSERT;
        end
      end

      ST_INSERT: begin
        ram_we     = 1'b1;
        ram_waddr  = pos[AW-1:0];
        ram_wdata  = {key_r, bal_r};
        count_next = count + CW'(1);
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_data_next.found         = res_found;
          rsp_data_next.found_balance = res_bal;
          rsp_data_next.over_limit    = res_found && (res_bal > spend_limit);
          rsp_data_next.rejected      = res_rej;
          rsp_valid_next              = 1'b1;
          state_next                  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      chk_valid <= 1'b0;
      chk_idx   <= '0;
      sidx      <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      chk_valid <= chk_valid_next;
      chk_idx   <= chk_idx_next;
      sidx      <= sidx_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_r_next;
    key_r     <= key_r_next;
    bal_r     <= bal_r_next;
    pos       <= pos_next;
    wa        <= wa_next;
    res_found <= res_found_next;
    res_bal   <= res_bal_next;
    res_rej   <= res_rej_next;
    rsp_data  <= rsp_data_next;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count beyond table depth");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_rej) |-> (count == FULL))
    else $error("load rejected while table has room");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not advance entry count");

  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CW'(ram_waddr) < FULL) && (CW'(ram_waddr) <= count))
    else $error("table write outside occupied range");

  a_rsp_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.found && rsp_data.rejected))
    else $error("response both found and rejected");
`endif

endmodule

### tb/sv/tb_sorted_key_table_lookup.sv
// ---------------------------------------------------------------------------
// tb_sorted_key_table_lookup: self-checking bench for the sorted key table
// Fills the table through a directed sequence of loads and searches that
// covers the empty table, duplicate keys, key and balance extremes, early
// stops and the full-table rejection. It then runs random searches and
// loads in phases, each under a different spend limit written over APB.
// Every response is checked field by field against an in-bench model of the
// table or a directed expectation. Both channels idle and stall at random throughout.
// ---------------------------------------------------------------------------
module tb_sorted_key_table_lookup;

  import skt_pkg::*;

  localparam int DEPTH           = TABLE_DEPTH_DEF;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int CYCLE_LIMIT     = 600000;
  localparam logic [APB_AW-1:0] SPEND_LIMIT_ADDR = APB_AW'(4 * int'(REG_SPEND_LIMIT));

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SLOW} rx_mode_e;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req_data = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_t              rsp_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Mirror of the table contents and of the spend limit register
  logic [KEY_W-1:0]   tbl_key [DEPTH];
  logic [CENTS_W-1:0] tbl_bal [DEPTH];
  int                 tbl_count = 0;
  logic [CENTS_W-1:0] cur_spend_limit = SPEND_LIMIT_RST;

  rsp_t        pending_rsp [$];
  stim_row_t   directed_rows [$];
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  bit          req_up = 1'b0;
  int          burst_left = 0;
  rx_mode_e    rx_mode = RX_FREE;
  int          rx_hold = 0;

  sorted_key_table_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // Apply one request to the table mirror and return the response it earns
  function automatic rsp_t apply_request(input req_t r);
    rsp_t res;
    int   pos;
    bit   stop;
    res  = '0;
    stop = 1'b0;
    if (r.cmd == CMD_LOAD) begin
      if (tbl_count >= DEPTH) begin
        res.rejected = 1'b1;
      end else begin
        // insert after any equal keys: first slot holding a greater key
        pos = tbl_count;
        for (int i = 0; i < tbl_count; i++) begin
          if (pos == tbl_count && tbl_key[i] > r.key) pos = i;
        end
        for (int i = tbl_count; i > pos; i--) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_bal[i] = tbl_bal[i-1];
        end
        tbl_key[pos] = r.key;
        tbl_bal[pos] = r.balance;
        tbl_count++;
      end
    end else begin
      // scan upward, stop on the oldest match or once keys pass the query
      for (int i = 0; i < tbl_count; i++) begin
        if (!stop && tbl_key[i] == r.key) begin
          res.found         = 1'b1;
          res.found_balance = tbl_bal[i];
          res.over_limit    = tbl_bal[i] > cur_spend_limit;
          stop              = 1'b1;
        end else if (tbl_key[i] > r.key) begin
          stop = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic rsp_t resp_of(input logic hit, input logic [CENTS_W-1:0] bal,
                                   input logic over, input logic rej);
    rsp_t res;
    res.found         = hit;
    res.found_balance = bal;
    res.over_limit    = over;
    res.rejected      = rej;
    return res;
  endfunction

  function automatic stim_row_t stim_row(input logic cmd, input logic [KEY_W-1:0] key,
                                         input logic [CENTS_W-1:0] bal,
                                         input bit typed = 1'b0, input rsp_t want = '0);
    stim_row_t row;
    row.req.cmd     = cmd;
    row.req.key     = key;
    row.req.balance = bal;
    row.typed       = typed;
    row.rsp         = want;
    return row;
  endfunction

  // Present one request, hold it until accepted, then pace the next burst
  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    int   gap;
    req_valid <= 1'b1;
    req_data  <= r;
    req_up     = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pred = apply_request(r);
    pending_rsp.push_back(typed ? want : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        req_valid <= 1'b0;
        req_up     = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and hold until every outstanding response has drained
  task automatic drain_responses();
    if (req_up) begin
      req_valid <= 1'b0;
      req_up     = 1'b0;
    end
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the spend limit, then read it back
  task automatic write_spend_limit(input logic [APB_DW-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SPEND_LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_spend_limit = wdata[CENTS_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CENTS_W-1:0] !== cur_spend_limit) begin
      $error("spend_limit readback: expected %0d, got %0d", cur_spend_limit,
             prdata[CENTS_W-1:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Response side: pick a new stall pattern whenever the random hold count runs out
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(2, 0));
      rx_hold <= $urandom_range(400, 100);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_FREE:   rsp_ready <= 1'b1;
      RX_RANDOM: rsp_ready <= 1'($urandom_range(1, 0));
      default:   rsp_ready <= ($urandom_range(11, 0) == 0);
    endcase
  end

  // Check each response transaction against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response transaction: %p", rsp_data);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp_data.found);
          fail_count++;
        end
        if (rsp_data.found_balance !== want.found_balance) begin
          $error("found_balance: expected %0d, got %0d", want.found_balance,
                 rsp_data.found_balance);
          fail_count++;
        end
        if (rsp_data.over_limit !== want.over_limit) begin
          $error("over_limit: expected %0d, got %0d", want.over_limit,
                 rsp_data.over_limit);
          fail_count++;
        end
        if (rsp_data.rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, rsp_data.rejected);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    req_t               r;
    int                 pick;
    int                 idx;
    logic [APB_DW-1:0]  limit_val;

    // Directed sequence, run under the reset spend limit of 10000
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'h0000, 24'h5A5A5A, 1,
                                     resp_of(0, 0, 0, 0)));
    directed_rows.push_back(stim_row(CMD_LOAD,   16'h8000, 24'd10001, 1,
                                     resp_of(0, 0, 0, 0)));
    directed_rows.push_back(stim_row(CMD_LOAD,   16'h8000, 24'd10000, 1,
                                     resp_of(0, 0, 0, 0)));
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'h8000, 24'hFFFFFF, 1,
                                     resp_of(1, 24'd10001, 1, 0)));
    directed_rows.push_back(stim_row(CMD_LOAD,   16'h0000, 24'd0, 1,
                                     resp_of(0, 0, 0, 0)));
    directed_rows.push_back(stim_row(CMD_LOAD,   16'hFFFF, 24'hFFFFFF, 1,
                                     resp_of(0, 0, 0, 0)));
    directed_rows.push_back(stim_row(CMD_LOAD,   16'h4000, 24'd10000, 1,
                                     resp_of(0, 0, 0, 0)));
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'h4000, 24'd0, 1,
                                     resp_of(1, 24'd10000, 0, 0)));
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'h0000, 24'd0, 1,
                                     resp_of(1, 24'd0, 0, 0)));
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'hFFFF, 24'd0, 1,
                                     resp_of(1, 24'hFFFFFF, 1, 0)));
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'h3FFF, 24'd0, 1,
                                     resp_of(0, 0, 0, 0)));
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'h8001, 24'd0, 1,
                                     resp_of(0, 0, 0, 0)));
    // fill the rest of the table in mixed key order, duplicates included
    directed_rows.push_back(stim_row(CMD_LOAD, 16'hFFFF, 24'd1));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'h0000, 24'h800000));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'h7FFF, 24'd9999));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'h0001, 24'h7FFFFF));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'hFFFE, 24'd123456));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'h1234, 24'hABCDEF));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'hAAAA, 24'h555555));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'h5555, 24'd10002));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'h8000, 24'hC00000));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'hC000, 24'h200000));
    directed_rows.push_back(stim_row(CMD_LOAD, 16'h2000, 24'h000002));
    // table now full: the next load must bounce
    directed_rows.push_back(stim_row(CMD_LOAD, 16'h1111, 24'd5, 1,
                                     resp_of(0, 0, 0, 1)));
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'h8000, 24'd0));
    directed_rows.push_back(stim_row(CMD_SEARCH, 16'hFFFF, 24'd0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end

    // Random phases, each under its own spend limit
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_responses();
      idx = (tbl_count > 0) ? $urandom_range(tbl_count - 1, 0) : 0;
      case (ph)
        0:       limit_val = '0;
        1:       limit_val = 32'hFFFF_FFFF;
        2:       limit_val = APB_DW'(SPEND_LIMIT_RST);
        3:       limit_val = APB_DW'(tbl_bal[idx]);
        4:       limit_val = APB_DW'(tbl_bal[idx] - 1'b1);
        5:       limit_val = APB_DW'(24'd1);
        default: limit_val = APB_DW'(CENTS_W'($urandom()));
      endcase
      write_spend_limit(limit_val);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r.balance = CENTS_W'($urandom());
        r.key     = KEY_W'($urandom());
        pick      = $urandom_range(99, 0);
        if (pick < 15) begin
          r.cmd = CMD_LOAD;
        end else begin
          // mostly stored keys and their neighbours, the rest arbitrary
          r.cmd = CMD_SEARCH;
          if (tbl_count > 0 && pick < 90) begin
            idx   = $urandom_range(tbl_count - 1, 0);
            r.key = tbl_key[idx];
            if (pick >= 65) r.key = $urandom_range(1, 0) ? r.key + 1'b1 : r.key - 1'b1;
          end
        end
        send_req(r, 1'b0, '0);
      end
    end

    drain_responses();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
